/* rtl/shfr_pkg.sv */
// ---------------------------------------------------------------------------
// shfr_pkg
// Shared types and constants for the sync header frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package shfr_pkg;

  localparam int unsigned CountWidth  = 9;
  localparam int unsigned HeaderBytes = 4;

  // Event codes reported with each word.
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_SYNC_MISS  = 3'd1;
  localparam logic [2:0] EV_HEADER_BAD = 3'd2;
  localparam logic [2:0] EV_COMPLETE   = 3'd3;
  localparam logic [2:0] EV_OVERFLOW   = 3'd4;
  localparam logic [2:0] EV_DROPPED    = 3'd5;

  // Register indexes on the configuration port.
  localparam logic REG_START_CHAR = 1'b0;
  localparam logic REG_RX_SIZE    = 1'b1;

  typedef struct packed {
    logic [7:0]            start_char;
    logic [CountWidth-1:0] rx_size;
    logic                  restart;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       stored;
    logic [7:0] byte_index;
    logic [2:0] event_res;
  } result_t;

endpackage

`default_nettype wire

/* rtl/shfr_cfg.sv */
// ---------------------------------------------------------------------------
// shfr_cfg
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
`default_nettype none

module shfr_cfg
  import shfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [7:0]            start_char;
  logic [CountWidth-1:0] rx_size;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= 8'd0;
      rx_size    <= 9'd256;
    end else if (wr_en) begin
      if (paddr[2] == REG_START_CHAR) begin
        start_char <= pwdata[7:0];
      end else begin
        rx_size <= pwdata[CountWidth-1:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_RX_SIZE) begin
      prdata = {{(32-CountWidth){1'b0}}, rx_size};
    end else begin
      prdata = {24'd0, start_char};
    end
  end

  // Writing the buffer size sends the receiver back to hunting.
  assign cfg.start_char = start_char;
  assign cfg.rx_size    = rx_size;
  assign cfg.restart    = wr_en && (paddr[2] == REG_RX_SIZE);

endmodule

`default_nettype wire

/* rtl/shfr_core.sv */
// ---------------------------------------------------------------------------
// shfr_core
// Framing state and the per-word decision logic.
// ---------------------------------------------------------------------------
`default_nettype none

module shfr_core
  import shfr_pkg::*;
#(
  parameter int unsigned BUF_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output result_t         result
);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  localparam int unsigned CountMax = (1 << CountWidth) - 1;
  localparam int unsigned LimCap   = (BUF_BYTES > CountMax) ? CountMax : BUF_BYTES;

  logic [1:0]            phase, phase_next;
  logic [CountWidth-1:0] byte_count, byte_count_next;
  logic [7:0]            header_sum, header_sum_next;
  logic [7:0]            header_check, header_check_next;
  logic [15:0]           frame_length, frame_length_next;

  logic [CountWidth-1:0] lim;
  logic [CountWidth-1:0] count_inc;
  logic [7:0]            sum_upd;
  logic [2:0]            ev;
  logic                  st;

  always_comb begin
    lim = (cfg.rx_size > CountWidth'(LimCap)) ? CountWidth'(LimCap) : cfg.rx_size;
  end

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    header_sum_next   = header_sum;
    header_check_next = header_check;
    frame_length_next = frame_length;
    count_inc         = byte_count + 1'b1;
    sum_upd           = header_sum;
    ev                = EV_NONE;
    st                = 1'b0;

    if (byte_count >= lim) begin
      ev = EV_DROPPED;
    end else begin
      st              = 1'b1;
      byte_count_next = count_inc;
      case (phase)
        PH_HEADER: begin
          if (byte_count == 9'd1) begin
            header_check_next = rx_byte;
          end else if (byte_count == 9'd2) begin
            sum_upd                = header_sum ^ rx_byte;
            frame_length_next[7:0] = rx_byte;
          end else if (byte_count == 9'd3) begin
            sum_upd                 = header_sum ^ rx_byte;
            frame_length_next[15:8] = rx_byte;
          end
          header_sum_next = sum_upd;
          // The check byte is compared against the sum including the last
          // length byte, so the freshly updated values are used here.
          if (count_inc == CountWidth'(HeaderBytes)) begin
            if (sum_upd != header_check_next) begin
              ev              = EV_HEADER_BAD;
              phase_next      = PH_HUNT;
              byte_count_next = '0;
            end else begin
              phase_next = PH_BODY;
            end
          end else if (count_inc > CountWidth'(HeaderBytes)) begin
            ev              = EV_HEADER_BAD;
            phase_next      = PH_HUNT;
            byte_count_next = '0;
          end
        end
        PH_BODY: begin
          // A frame that completes exactly at the limit is not an overflow.
          if ({7'd0, count_inc} == frame_length) begin
            ev              = EV_COMPLETE;
            phase_next      = PH_HUNT;
            byte_count_next = '0;
          end else if (count_inc >= lim) begin
            ev              = EV_OVERFLOW;
            phase_next      = PH_HUNT;
            byte_count_next = '0;
          end
        end
        default: begin
          if (rx_byte != cfg.start_char) begin
            ev              = EV_SYNC_MISS;
            phase_next      = PH_HUNT;
            byte_count_next = '0;
          end else begin
            header_sum_next = rx_byte;
            phase_next      = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_count   <= '0;
      header_sum   <= 8'd0;
      header_check <= 8'd0;
      frame_length <= 16'd0;
    end else if (cfg.restart) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      header_sum   <= header_sum_next;
      header_check <= header_check_next;
      frame_length <= frame_length_next;
    end
  end

  assign result.byte_value = rx_byte;
  assign result.stored     = st;
  assign result.byte_index = byte_count[7:0];
  assign result.event_res  = ev;

endmodule

`default_nettype wire

/* rtl/shfr_out.sv */
// ---------------------------------------------------------------------------
// shfr_out
// Output register holding one result word until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module shfr_out
  import shfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result_in,
  input  wire logic    out_stall,
  output logic         out_valid,
  output logic         can_load,
  output result_t      result_out
);

  // A new word may enter when the register is empty or is emptied this cycle.
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/sync_header_frame_receiver_unit.sv */
// ---------------------------------------------------------------------------
// sync_header_frame_receiver_unit
// Frames packets with a start byte and a 4-byte checked header.
//
// Input channel: rx_byte with in_valid / in_stall; one received byte per word.
// Output channel: byte_value, stored, byte_index, event_res with out_valid /
// out_stall; exactly one result word for every accepted byte, in order.
// Configuration: APB-style port; start_char at address 0, rx_size at 4.
// Writing rx_size sends the receiver back to hunting for a start byte.
//
// A byte accepted at a clock edge shows its result after that edge. Throughput
// is one byte per cycle while out_stall is low, set by the single output
// register, which takes a new word in the same cycle its old one leaves.
// While out_stall holds a full output register, in_stall is raised and the
// framing state does not advance. Reset empties the output register, sets
// start_char to 0 and rx_size to 256, and returns to hunting.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_header_frame_receiver_unit
  import shfr_pkg::*;
#(
  parameter int unsigned BUF_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       byte_value,
  output logic             stored,
  output logic [7:0]       byte_index,
  output logic [2:0]       event_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  result_t core_result;
  result_t held_result;
  logic    can_load;
  logic    accept;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  shfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shfr_core #(
    .BUF_BYTES (BUF_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (rx_byte),
    .result  (core_result)
  );

  shfr_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (core_result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .can_load   (can_load),
    .result_out (held_result)
  );

  assign byte_value = held_result.byte_value;
  assign stored     = held_result.stored;
  assign byte_index = held_result.byte_index;
  assign event_res  = held_result.event_res;

endmodule

`default_nettype wire

/* dv/tb_sync_header_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sync_header_frame_receiver_unit
// Self-checking testbench for the sync header frame receiver. A software
// copy of the framing state predicts the result word for every accepted
// byte. Directed frames cover sync misses, bad headers, short lengths,
// overflow, completion at the buffer limit and dropped bytes. Random
// frames run under several start byte and buffer size settings, with
// random gaps on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_sync_header_frame_receiver_unit;
  import shfr_pkg::*;

  localparam int unsigned BufBytes   = 256;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 60;

  typedef enum logic [1:0] {
    S_HUNT,
    S_HEADER,
    S_BODY
  } rx_state_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  byte_value;
  logic        stored;
  logic [7:0]  byte_index;
  logic [2:0]  event_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted framing state and register copies.
  rx_state_e   rx_state;
  logic [8:0]  rx_count;
  logic [7:0]  hdr_xor;
  logic [7:0]  hdr_check;
  logic [15:0] frame_len;
  logic [7:0]  cfg_start;
  logic [8:0]  cfg_size;

  result_t     pending_results[$];
  int unsigned fail_count   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cycles  = 0;
  int unsigned burst_left   = 0;
  bit          idling       = 1'b1;

  sync_header_frame_receiver_unit #(
    .BUF_BYTES(BufBytes)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .byte_value(byte_value),
    .stored    (stored),
    .byte_index(byte_index),
    .event_res (event_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned buffer_limit();
    return (cfg_size > BufBytes) ? BufBytes : int'(cfg_size);
  endfunction

  function automatic void resync();
    rx_state = S_HUNT;
    rx_count = '0;
  endfunction

  function automatic result_t next_frame_result(logic [7:0] b);
    result_t     r;
    int unsigned lim;
    logic [8:0]  idx;
    lim = buffer_limit();
    idx = rx_count;
    r.byte_value = b;
    r.stored     = 1'b0;
    r.byte_index = idx[7:0];
    r.event_res  = EV_NONE;
    if (rx_count >= lim) begin
      r.event_res = EV_DROPPED;
    end else begin
      r.stored = 1'b1;
      rx_count = rx_count + 9'd1;
      case (rx_state)
        S_HEADER: begin
          if (idx == 9'd1) begin
            hdr_check = b;
          end else if (idx == 9'd2) begin
            hdr_xor ^= b;
            frame_len[7:0] = b;
          end else if (idx == 9'd3) begin
            hdr_xor ^= b;
            frame_len[15:8] = b;
          end
          if (rx_count == HeaderBytes) begin
            if (hdr_xor != hdr_check) begin
              r.event_res = EV_HEADER_BAD;
              resync();
            end else begin
              rx_state = S_BODY;
            end
          end else if (rx_count > HeaderBytes) begin
            r.event_res = EV_HEADER_BAD;
            resync();
          end
        end
        S_BODY: begin
          if ({7'd0, rx_count} == frame_len) begin
            r.event_res = EV_COMPLETE;
            resync();
          end
          if (rx_count >= lim) begin
            r.event_res = EV_OVERFLOW;
            resync();
          end
        end
        default: begin
          if (b != cfg_start) begin
            r.event_res = EV_SYNC_MISS;
            resync();
          end else begin
            hdr_xor  = b;
            rx_state = S_HEADER;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
    fail_count++;
  endtask

  // Checks each result word against the oldest prediction and predicts
  // every accepted byte.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: byte_value %0d event_res %0d", byte_value,
                 event_res);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (byte_value !== want.byte_value)
            note_mismatch("byte_value", want.byte_value, byte_value);
          if (stored !== want.stored) note_mismatch("stored", want.stored, stored);
          if (byte_index !== want.byte_index)
            note_mismatch("byte_index", want.byte_index, byte_index);
          if (event_res !== want.event_res)
            note_mismatch("event_res", want.event_res, event_res);
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(next_frame_result(rx_byte));
    end
  end

  // Receiver side: random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (burst_left != 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[sync_header_frame_receiver_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(logic reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_START_CHAR) begin
      cfg_start = value[7:0];
    end else begin
      cfg_size = value[8:0];
      resync();
    end
  endtask

  // Registers change only once the block has drained.
  task automatic reconfigure(logic [7:0] start_char, logic [8:0] rx_size);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_START_CHAR, {24'd0, start_char});
    write_reg(REG_RX_SIZE, {23'd0, rx_size});
  endtask

  // Mostly well-formed frames with random content; some carry a bad
  // checksum, an unreachable length or a truncated body.
  task automatic send_frame();
    int unsigned lim;
    int unsigned kind;
    int unsigned body;
    logic [15:0] len;
    logic [7:0]  chk;
    logic [7:0]  noise;
    lim  = buffer_limit();
    kind = $urandom_range(0, 19);
    repeat ($urandom_range(0, 2)) begin
      noise = 8'($urandom);
      if (noise == cfg_start) noise = ~noise;
      send_byte(noise);
    end
    if (kind < 13) len = 16'($urandom_range(5, (lim < 24) ? lim : 24));
    else if (kind == 13) len = 16'($urandom_range(5, lim));
    else if (kind == 14) len = 16'(lim);
    else if (kind == 15) len = 16'($urandom_range(0, 4));
    else if (kind == 16) len = 16'($urandom_range(lim + 1, 65535));
    else len = 16'($urandom);
    chk = cfg_start ^ len[7:0] ^ len[15:8];
    if ($urandom_range(0, 9) == 0) chk ^= 8'(1 << $urandom_range(0, 7));
    send_byte(cfg_start);
    send_byte(chk);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (chk == (cfg_start ^ len[7:0] ^ len[15:8])) begin
      body = (len >= 5 && len <= lim) ? len - 4 : lim - 4;
      if ($urandom_range(0, 11) == 0) body = $urandom_range(0, body);
      repeat (body) send_byte(8'($urandom));
    end
  endtask

  task automatic test_sync_and_header();
    send_byte(8'hFF);
    send_byte(8'h7E);
    // Length 5 frame with one body byte.
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h3C);
    // Checksum does not match.
    send_byte(8'h00);
    send_byte(8'h11);
    send_byte(8'h05);
    send_byte(8'h00);
  endtask

  task automatic test_frame_limits();
    reconfigure(8'hA5, 9'd5);
    // A length of 3 is never reached, so the frame overflows.
    send_byte(8'hA5);
    send_byte(8'hA6);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'hC3);
    // Length equal to the limit completes without an overflow.
    send_byte(8'hA5);
    send_byte(8'hA0);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h81);
  endtask

  task automatic test_tiny_buffer();
    reconfigure(8'hFF, 9'd0);
    send_byte(8'h00);
    // A limit below the header size leaves the receiver stuck.
    reconfigure(8'hFF, 9'd2);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_byte(8'h34);
  endtask

  task automatic test_random_frames();
    logic [8:0]  sizes[6];
    int unsigned target;
    sizes = '{9'd511, 9'd256, 9'd5, 9'd64, 9'd255, 9'd300};
    sizes[3] = 9'($urandom_range(6, 40));
    for (int p = 0; p < 6; p++) begin
      reconfigure((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom), sizes[p]);
      target = bytes_sent + 30;
      while (bytes_sent < target) send_frame();
    end
  endtask

  task automatic test_backpressure();
    idling = 1'b0;
    reconfigure(8'($urandom), 9'd32);
    hold_cycles = HoldCycles;
    repeat (3) send_frame();
  endtask

  task automatic test_streaming();
    int unsigned target;
    idling = 1'b0;
    reconfigure(8'($urandom), 9'($urandom_range(5, 511)));
    target = bytes_sent + 40;
    while (bytes_sent < target) send_frame();
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = 8'd0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cfg_start = 8'd0;
    cfg_size  = 9'd256;
    hdr_xor   = 8'd0;
    hdr_check = 8'd0;
    frame_len = 16'd0;
    resync();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sync_and_header();
    test_frame_limits();
    test_tiny_buffer();
    test_random_frames();
    test_backpressure();
    test_streaming();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sync_header_frame_receiver_unit] OK");
    end else begin
      $display("[sync_header_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
